// ===== rtl/vfb_pkg.sv =====
// ----------------------------------------------------------------------------
// vfb_pkg
// Types, constants and helpers for the segmented vector ARMA filter.
// ----------------------------------------------------------------------------
package vfb_pkg;

    localparam int CHANNELS  = 2;
    localparam int SLOTS     = 2;
    localparam int MAX_LAG   = 8;
    localparam int SEGMENTS  = 4;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 52;

    localparam logic [1:0] OP_COEF    = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] REG_AR_LAG_A = 3'd0;
    localparam logic [2:0] REG_AR_LAG_B = 3'd1;
    localparam logic [2:0] REG_MA_LAG_A = 3'd2;
    localparam logic [2:0] REG_MA_LAG_B = 3'd3;
    localparam logic [2:0] REG_SEG_CNT  = 3'd4;
    localparam logic [2:0] REG_BP1      = 3'd5;
    localparam logic [2:0] REG_BP2      = 3'd6;
    localparam logic [2:0] REG_BP3      = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] noise_0;
        logic signed [31:0] noise_1;
        logic               coef_bank;
        logic [1:0]         coef_segment;
        logic               coef_slot;
        logic               coef_row;
        logic               coef_col;
        logic signed [31:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] series_0;
        logic signed [31:0] series_1;
        logic [1:0]         segment;
        logic               saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_SAT,
        ST_WRITE
    } state_t;

    // MAC unit control
    typedef struct packed {
        logic               clear;
        logic               enable;
        logic               negate;
        logic signed [31:0] init;
    } mac_ctl_t;

    function automatic logic [3:0] clamp_lag(input logic [3:0] l);
        return (l > 4'(MAX_LAG)) ? 4'(MAX_LAG) : l;
    endfunction

endpackage

// ===== rtl/vfb_mac.sv =====
// ----------------------------------------------------------------------------
// vfb_mac
// Shared multiply-accumulate: registered product, rounded Q.F, wide sum.
// ----------------------------------------------------------------------------
module vfb_mac
    import vfb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [31:0]      a,
    input  logic signed [31:0]      b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [63:0]      prod_reg;
    logic                    pvalid_reg;
    logic                    pneg_reg;
    logic signed [63:0]      rnd;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_reg;

    always_comb
    begin
        rnd  = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
        term = ACC_W'(rnd >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        pneg_reg <= ctl.negate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            pvalid_reg <= ctl.enable;
            if (ctl.clear)
                acc_reg <= ACC_W'($signed(ctl.init));
            else if (pvalid_reg)
                acc_reg <= pneg_reg ? acc_reg - term : acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/varma_filter_with_breaks.sv =====
// ----------------------------------------------------------------------------
// varma_filter_with_breaks
// Two-channel vector ARMA filter with break-point coefficient segments.
// Noise item: per row, setup, MAC steps incl. multiplier fill and drain, and
//   saturation; then history write. In warm-up, setup goes straight to write.
// Coefficient and restart items complete in idle. A held result stalls the next write.
// Reset: registers to defaults; all 64 coefficient words cleared, not ready meanwhile.
// ----------------------------------------------------------------------------
module varma_filter_with_breaks
    import vfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic [3:0]  lag_reg [4];
    logic [2:0]  segcnt_reg;
    logic [31:0] bp_reg [3];

    logic [31:0] coef_mem [64];
    logic [31:0] coef_rd_reg;
    logic signed [31:0] nh_mem [MAX_LAG][CHANNELS];
    logic signed [31:0] sh_mem [MAX_LAG][CHANNELS];

    state_t state_reg, state_next;
    logic [6:0]  clr_reg;
    logic        clr_busy;
    logic [2:0]  hp_reg;
    logic [31:0] cnt_reg;
    in_item_t    item_reg;
    logic [1:0]  seg_reg;
    logic        warm_reg;
    logic [4:0]  step_reg;
    logic        row_reg;
    logic signed [31:0] res_reg [2];
    logic        sat_reg;
    out_item_t   out_reg;
    logic        ov_reg;
    logic        out_free;

    mac_ctl_t ctl;
    logic signed [ACC_W-1:0] acc;
    logic signed [31:0] mac_a, mac_b;
    logic [3:0] maxlag;
    logic [1:0] seg_calc;
    logic [2:0] nseg;

    // step: [2]=bank(0 MA,1 AR order), [1]=slot, [0]=col ; fetch at step, MAC at step-1
    logic [2:0] sstep;
    logic       s_bank, s_slot, s_col;
    logic [3:0] s_lag;
    logic [2:0] s_h;
    logic [5:0] rd_addr;
    logic       p_bank, p_col;
    logic [3:0] p_lag;
    logic [2:0] p_h;

    assign clr_busy = !clr_reg[6];
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        maxlag = 4'd0;
        for (int i = 0; i < 4; i++)
            if (clamp_lag(lag_reg[i]) > maxlag)
                maxlag = clamp_lag(lag_reg[i]);
        nseg = (segcnt_reg == 3'd0) ? 3'd1 : ((segcnt_reg > 3'd4) ? 3'd4 : segcnt_reg);
        seg_calc = 2'd0;
        for (int i = 1; i < 4; i++)
            if (3'(i) < nseg && cnt_reg >= bp_reg[i-1])
                seg_calc = 2'(i);
    end

    // fetch-side decode (step_reg 0..7), bank 1 (MA) first then AR
    always_comb
    begin
        sstep  = step_reg[2:0];
        s_bank = !sstep[2];
        s_slot = sstep[1];
        s_col  = sstep[0];
        s_lag  = clamp_lag(s_bank ? lag_reg[{1'b1, s_slot}] : lag_reg[{1'b0, s_slot}]);
        s_h    = 3'(hp_reg - s_lag[2:0]);
        rd_addr = {s_bank, seg_reg, s_slot, row_reg, s_col};
    end

    logic       p_valid_reg;
    logic       pb_reg, pc_reg;
    logic [3:0] pl_reg;
    logic [2:0] ph_reg;
    assign p_bank = pb_reg;
    assign p_col  = pc_reg;
    assign p_lag  = pl_reg;
    assign p_h    = ph_reg;

    always_comb
    begin
        mac_a = coef_rd_reg;
        if (p_bank)
            mac_b = nh_mem[p_h][p_col];
        else
            mac_b = sh_mem[p_h][p_col];
        ctl.clear  = (state_reg == ST_SETUP);
        ctl.init   = row_reg ? item_reg.noise_1 : item_reg.noise_0;
        ctl.enable = (state_reg == ST_MAC) && p_valid_reg && (p_lag != 4'd0);
        ctl.negate = p_bank;
    end

    vfb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = (in_data.opcode == OP_SAMPLE) ? ST_SETUP : ST_IDLE;
            ST_SETUP: state_next = warm_reg ? ST_WRITE : ST_MAC;
            ST_MAC:   if (step_reg == 5'd10) state_next = ST_SAT;
            ST_SAT:   state_next = row_reg ? ST_WRITE : ST_SETUP;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && !clr_busy;
    end

    logic signed [31:0] sat_val;
    logic               sat_hit;
    always_comb
    begin
        sat_hit = 1'b0;
        sat_val = acc[31:0];
        if (acc > ACC_W'(64'sh7FFFFFFF))
        begin
            sat_val = 32'sh7FFFFFFF;
            sat_hit = 1'b1;
        end
        else if (acc < -ACC_W'(64'sh80000000))
        begin
            sat_val = 32'sh80000000;
            sat_hit = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy)
            coef_mem[clr_reg[5:0]] <= '0;
        else if (state_reg == ST_IDLE && in_valid && in_data.opcode == OP_COEF)
            coef_mem[{in_data.coef_bank, in_data.coef_segment, in_data.coef_slot,
                      in_data.coef_row, in_data.coef_col}] <= in_data.coef_value;
        coef_rd_reg <= coef_mem[rd_addr];
        if (state_reg == ST_IDLE && in_valid && in_ready)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg   <= '0;
            for (int i = 0; i < 4; i++) lag_reg[i] <= '0;
            segcnt_reg <= 3'd1;
            for (int i = 0; i < 3; i++) bp_reg[i] <= '0;
            hp_reg    <= '0;
            cnt_reg   <= '0;
            seg_reg   <= '0;
            warm_reg  <= 1'b0;
            step_reg  <= '0;
            row_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            pb_reg <= 1'b0;
            pc_reg <= 1'b0;
            pl_reg <= '0;
            ph_reg <= '0;
            for (int i = 0; i < 2; i++) res_reg[i] <= '0;
            for (int i = 0; i < MAX_LAG; i++)
                for (int c = 0; c < CHANNELS; c++)
                begin
                    nh_mem[i][c] <= '0;
                    sh_mem[i][c] <= '0;
                end
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy) clr_reg <= clr_reg + 7'd1;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AR_LAG_A: lag_reg[0] <= cfg_data[3:0];
                    REG_AR_LAG_B: lag_reg[1] <= cfg_data[3:0];
                    REG_MA_LAG_A: lag_reg[2] <= cfg_data[3:0];
                    REG_MA_LAG_B: lag_reg[3] <= cfg_data[3:0];
                    REG_SEG_CNT:  segcnt_reg <= cfg_data[2:0];
                    REG_BP1:      bp_reg[0]  <= cfg_data;
                    REG_BP2:      bp_reg[1]  <= cfg_data;
                    default:      bp_reg[2]  <= cfg_data;
                endcase
            end
            ov_reg <= ((state_reg == ST_WRITE) && out_free) || (ov_reg && !out_ready);
            p_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_valid && in_ready)
                    begin
                        row_reg <= 1'b0;
                        sat_reg <= 1'b0;
                        seg_reg <= seg_calc;
                        warm_reg <= ({28'd0, maxlag} > cnt_reg);
                        if (in_data.opcode == OP_RESTART)
                        begin
                            hp_reg  <= '0;
                            cnt_reg <= '0;
                            for (int i = 0; i < MAX_LAG; i++)
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    nh_mem[i][c] <= '0;
                                    sh_mem[i][c] <= '0;
                                end
                        end
                    end
                ST_SETUP:
                begin
                    step_reg <= '0;
                    if (warm_reg)
                        for (int i = 0; i < 2; i++) res_reg[i] <= '0;
                end
                ST_MAC:
                begin
                    step_reg <= step_reg + 5'd1;
                    p_valid_reg <= (step_reg < 5'd8);
                    pb_reg <= s_bank;
                    pc_reg <= s_col;
                    pl_reg <= s_lag;
                    ph_reg <= s_h;
                end
                ST_SAT:
                begin
                    res_reg[row_reg] <= sat_val;
                    sat_reg <= sat_reg | sat_hit;
                    row_reg <= 1'b1;
                end
                ST_WRITE:
                    if (out_free)
                    begin
                        nh_mem[hp_reg][0] <= item_reg.noise_0;
                        nh_mem[hp_reg][1] <= item_reg.noise_1;
                        sh_mem[hp_reg][0] <= res_reg[0];
                        sh_mem[hp_reg][1] <= res_reg[1];
                        hp_reg <= hp_reg + 3'd1;
                        if (cnt_reg != 32'hFFFFFFFF) cnt_reg <= cnt_reg + 32'd1;
                        out_reg.series_0  <= res_reg[0];
                        out_reg.series_1  <= res_reg[1];
                        out_reg.segment   <= seg_reg;
                        out_reg.saturated <= sat_reg & !warm_reg;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/vfb_checker.sv =====
// ----------------------------------------------------------------------------
// vfb_checker
// Port-level checks for the ARMA filter.
// ----------------------------------------------------------------------------
module vfb_checker
    import vfb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode == OP_SAMPLE |=> !in_ready)
        else $error("ready right after sample accept");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("unknown bits in output item");

endmodule

bind varma_filter_with_breaks vfb_checker u_vfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
